>>> hw/rtl/jkv_pkg.sv
// ----------------------------------------------------------------------------
// jkv_pkg: shared types and constants for the JSON key/value extractor
// Item layouts, result status codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package jkv_pkg;

  localparam int KEY_MAX_DEF = 32;   // default longest key
  localparam int KEY_LEN_W   = 6;    // key_length register width
  localparam int KEY_BYTES   = 32;   // bytes held by the four key words
  localparam int KEY_IDX_W   = 5;    // index into the key bytes
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3     = 3'd5;

  // result status codes
  localparam logic [1:0] ST_CHAR   = 2'd0;
  localparam logic [1:0] ST_STRING = 2'd1;
  localparam logic [1:0] ST_INT    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  // value_mode codes
  localparam logic MODE_STRING = 1'b0;
  localparam logic MODE_INT    = 1'b1;

  // characters
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       body_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         char_out;
    logic signed [63:0] number;
    logic               run_last;
  } out_item_t;

endpackage

>>> hw/rtl/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor: streaming key lookup in a JSON text body
// Searches each body for "key", then returns its string or integer value.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one body byte per item, body_end set on the last byte of a body.
//   out_* : result items. String mode gives one status-char item per value
//           character, then string-complete (or absent). Integer mode gives one
//           integer-found or absent item. run_last marks the final item of a
//           body; every body gets exactly one.
//   cfg_* : plain write port, cfg_index selects value_mode, key_length or one
//           of the four key words. Write only while the block is idle.
// Timing:
//   One item per cycle sustained while in_stall is low. A result is visible on
//   out_* the cycle after its input item is accepted, or it waits in the skid
//   entry if the output is stalled. The rate rests on the state update: the
//   key window compare and the times-ten accumulate are both combinational.
// Reset (synchronous, rst_n low): registers cleared, body state at the start
//   of a search, output buffer empty.
// Stall: results sit in a two-entry buffer (output register plus skid).
//   in_stall rises only when the skid entry is occupied.
// ----------------------------------------------------------------------------
module json_key_value_extractor #(
  parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jkv_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jkv_pkg::out_item_t             out_item,
  input  logic                           cfg_wr_en,
  input  logic [jkv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jkv_pkg::*;

  localparam int WIN_DEPTH = KEY_MAX + 2;              // quote + key + quote
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

  // body phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_STRING = 3'd2;
  localparam logic [2:0] PH_INT    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // configuration
  logic                         mode_r;
  logic [KEY_LEN_W-1:0]         key_len_r;
  logic [3:0][CFG_DATA_W-1:0]   key_w_r;
  logic [KEY_BYTES-1:0][7:0]    key_bytes;

  // body state
  logic [7:0]        win_r [WIN_DEPTH];  // newest byte at tap 0
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [2:0]        phase_r, phase_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic              seen_r, seen_nxt;

  // output buffer
  logic      out_vld_r, skid_vld_r;
  out_item_t out_r, skid_r;

  // per-item work
  logic                 accept;
  logic [7:0]           b;
  logic                 end_b;
  logic                 shift_win;
  logic                 match;
  logic [KEY_LEN_W-1:0] klen, kidx;
  logic [KEY_LEN_W:0]   plen;
  logic [7:0]           cur;
  logic                 is_digit, is_skip;
  logic [3:0]           dig;
  logic [67:0]          acc10;
  logic [67:0]          limit;
  logic                 ovf;
  logic [63:0]          val;
  logic                 res_vld, final_out;
  out_item_t            res;

  assign key_bytes = key_w_r;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  assign b        = in_item.text_byte;
  assign end_b    = in_item.body_end;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign is_skip  = (b == CHAR_COLON) || (b == CHAR_SPACE) || (b == CHAR_TAB);
  assign dig      = 4'(b - CHAR_ZERO);

  // ---- key window compare, against the window after this byte shifts in ----
  always_comb begin
    klen  = (key_len_r > KEY_LEN_W'(KEY_MAX)) ? KEY_LEN_W'(KEY_MAX) : key_len_r;
    plen  = {1'b0, klen} + (KEY_LEN_W+1)'(2);
    fill_inc = (fill_r == FILL_W'(WIN_DEPTH)) ? fill_r : fill_r + 1'b1;
    match = ((KEY_LEN_W+1)'(fill_inc) >= plen);
    cur   = b;
    kidx  = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      cur  = (k == 0) ? b : win_r[(k == 0) ? 0 : k - 1];
      kidx = KEY_LEN_W'(k);
      if (kidx == '0 || kidx == klen + 1'b1) begin
        if (cur != CHAR_QUOTE) match = 1'b0;
      end else if (kidx <= klen) begin
        // tap k holds key character klen-k
        if (cur != key_bytes[KEY_IDX_W'(klen - kidx)]) match = 1'b0;
      end
    end
  end

  // ---- integer accumulate: acc*10 + d, checked against the signed limit ----
  always_comb begin
    acc10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, dig};
    limit = neg_r ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);
    ovf   = (acc10 > limit);
  end

  // ---- phase logic ----
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    fill_nxt  = fill_r;
    shift_win = 1'b0;
    res_vld   = 1'b0;
    final_out = 1'b0;
    val       = '0;
    res       = '{status: ST_ABSENT, char_out: 8'd0, number: 64'sd0, run_last: 1'b1};

    unique case (phase_r)
      PH_SEARCH: begin
        shift_win = 1'b1;
        fill_nxt  = fill_inc;
        if (match) phase_nxt = PH_SKIP;
        if (end_b) begin
          res_vld   = 1'b1;
          final_out = 1'b1;
        end
      end
      PH_SKIP: begin
        if (is_skip) begin
          if (end_b) begin
            res_vld   = 1'b1;
            final_out = 1'b1;
          end
        end else if (mode_r == MODE_STRING) begin
          if (b == CHAR_QUOTE && !end_b) begin
            phase_nxt = PH_STRING;
          end else begin
            res_vld   = 1'b1;
            final_out = 1'b1;
          end
        end else if (b == CHAR_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_INT;
          if (end_b) begin
            res_vld   = 1'b1;
            final_out = 1'b1;
          end
        end else if (is_digit) begin
          acc_nxt   = {60'd0, dig};
          seen_nxt  = 1'b1;
          phase_nxt = PH_INT;
          if (end_b) begin
            res_vld    = 1'b1;
            final_out  = 1'b1;
            res.status = ST_INT;
            res.number = $signed({60'd0, dig});
          end
        end else begin
          res_vld   = 1'b1;
          final_out = 1'b1;
        end
      end
      PH_STRING: begin
        res_vld = 1'b1;
        if (b == CHAR_QUOTE) begin
          final_out  = 1'b1;
          res.status = ST_STRING;
        end else if (end_b) begin
          final_out = 1'b1;
        end else begin
          res.status   = ST_CHAR;
          res.char_out = b;
          res.run_last = 1'b0;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          if (ovf) begin
            res_vld   = 1'b1;
            final_out = 1'b1;
          end else begin
            acc_nxt  = acc10[63:0];
            seen_nxt = 1'b1;
            if (end_b) begin
              val        = neg_r ? (64'd0 - acc10[63:0]) : acc10[63:0];
              res_vld    = 1'b1;
              final_out  = 1'b1;
              res.status = ST_INT;
              res.number = $signed(val);
            end
          end
        end else begin
          res_vld   = 1'b1;
          final_out = 1'b1;
          if (seen_r) begin
            val        = neg_r ? (64'd0 - acc_r) : acc_r;
            res.status = ST_INT;
            res.number = $signed(val);
          end
        end
      end
      default: ;  // done: ignore bytes until body end
    endcase

    if (end_b) begin
      phase_nxt = PH_SEARCH;
      fill_nxt  = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      seen_nxt  = 1'b0;
    end else if (final_out) begin
      phase_nxt = PH_DONE;
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STRING;
      key_len_r <= '0;
      key_w_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VALUE_MODE: mode_r     <= cfg_data[0];
        REG_KEY_LENGTH: key_len_r  <= cfg_data[KEY_LEN_W-1:0];
        REG_KEY_W0:     key_w_r[0] <= cfg_data;
        REG_KEY_W1:     key_w_r[1] <= cfg_data;
        REG_KEY_W2:     key_w_r[2] <= cfg_data;
        REG_KEY_W3:     key_w_r[3] <= cfg_data;
        default: ;  // no register at this index
      endcase
    end
  end

  // ---- body state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      fill_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // window taps beyond fill_r are never compared, so no reset needed
  always_ff @(posedge clk) begin
    if (accept && shift_win) begin
      win_r[0] <= b;
      for (int k = 1; k < WIN_DEPTH; k++) win_r[k] <= win_r[k-1];
    end
  end

  // ---- output register plus skid ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= accept && res_vld;
      end
    end else if (accept && res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) out_r <= skid_r;
      else            out_r <= res;
    end else if (accept && res_vld) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid filled without a stalled output");

  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == ST_CHAR) |-> !out_r.run_last)
    else $error("string character item marked last");

  a_body_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_b) |=> (phase_r == PH_SEARCH && fill_r == '0 && acc_r == '0))
    else $error("body state not cleared after body end");

  a_pos_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_INT && !neg_r) |-> !acc_r[63])
    else $error("positive magnitude beyond signed range");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for json_key_value_extractor
// Streams text bodies into the extractor under random idle and stall, keeps a
// cycle-free copy of the key search and value parse, and compares every result
// item field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import jkv_pkg::*;

  localparam int WIN_DEPTH  = KEY_MAX_DEF + 2;  // quote + key + quote
  localparam int QUIET_MAX  = 3000;             // cycles with no handshake at all
  localparam int DRAIN_WAIT = 4;                // covers items that give no result

  // body scan phases of the predictor
  typedef enum logic [2:0] {
    SCAN_SEEK, SCAN_SEP, SCAN_STRING, SCAN_NUMBER, SCAN_DONE
  } scan_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  json_key_value_extractor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  out_item_t   extract_results[$];   // results still owed by the block
  logic [7:0]  body_q[$];            // body being built for sending
  logic [7:0]  key_bytes[32];        // key as written, used to build bodies
  int          errors     = 0;
  int          bytes_sent = 0;
  int          idle_pct   = 31;      // sender gap chance per offer, in percent
  int          stall_pct  = 31;      // receiver stall chance per cycle
  int          hold_left  = 0;       // long receiver hold-off, counted below

  // predictor copy of the registers
  logic        cfg_mode;
  logic [5:0]  cfg_klen;
  logic [63:0] key_word[4];

  // predictor copy of the per-body state
  logic [7:0]  window[WIN_DEPTH];    // newest byte at index 0
  int          fill;
  scan_t       scan;
  logic [63:0] mag;
  logic        neg;
  logic        have_digit;
  logic        body_closed;          // final result already owed for this body

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_body();
    for (int k = 0; k < WIN_DEPTH; k++) window[k] = 8'h00;
    fill        = 0;
    scan        = SCAN_SEEK;
    mag         = '0;
    neg         = 1'b0;
    have_digit  = 1'b0;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // byte i of "key": quote, key characters, quote
  function automatic logic [7:0] pattern_at(int i, int klen);
    if (i == 0 || i == klen + 1) return CHAR_QUOTE;
    return key_word[(i - 1) / 8][((i - 1) % 8) * 8 +: 8];
  endfunction

  function automatic logic key_in_window();
    int klen;
    int plen;
    klen = (cfg_klen > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(cfg_klen);
    plen = klen + 2;
    if (fill < plen) return 1'b0;
    for (int k = 0; k < plen; k++) begin
      if (window[k] != pattern_at(plen - 1 - k, klen)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void owe(logic [1:0] st, logic [7:0] ch, logic [63:0] num,
                              logic last);
    out_item_t r;
    r.status   = st;
    r.char_out = ch;
    r.number   = num;
    r.run_last = last;
    extract_results.push_back(r);
    if (last) body_closed = 1'b1;
  endfunction

  function automatic logic [63:0] signed_value();
    return neg ? (64'd0 - mag) : mag;
  endfunction

  // one accepted body byte: advance the scan, queue any result it causes
  function automatic void scan_byte(logic [7:0] b, logic last);
    logic [63:0] d;
    logic [63:0] lim;
    d = {56'd0, b - CHAR_ZERO};
    body_closed = 1'b0;
    case (scan)
      SCAN_SEEK: begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (fill < WIN_DEPTH) fill++;
        if (key_in_window()) scan = SCAN_SEP;
        if (last) owe(ST_ABSENT, 8'h00, '0, 1'b1);
      end
      SCAN_SEP: begin
        if (b == CHAR_COLON || b == CHAR_SPACE || b == CHAR_TAB) begin
          if (last) owe(ST_ABSENT, 8'h00, '0, 1'b1);
        end else if (cfg_mode == MODE_STRING) begin
          // a quote on the final byte cannot open a value
          if (b == CHAR_QUOTE && !last) scan = SCAN_STRING;
          else owe(ST_ABSENT, 8'h00, '0, 1'b1);
        end else if (b == CHAR_MINUS) begin
          neg  = 1'b1;
          scan = SCAN_NUMBER;
          if (last) owe(ST_ABSENT, 8'h00, '0, 1'b1);
        end else if (is_digit(b)) begin
          mag        = d;
          have_digit = 1'b1;
          scan       = SCAN_NUMBER;
          if (last) owe(ST_INT, 8'h00, mag, 1'b1);
        end else begin
          owe(ST_ABSENT, 8'h00, '0, 1'b1);
        end
      end
      SCAN_STRING: begin
        if (b == CHAR_QUOTE) owe(ST_STRING, 8'h00, '0, 1'b1);
        else if (last) owe(ST_ABSENT, 8'h00, '0, 1'b1);
        else owe(ST_CHAR, b, '0, 1'b0);
      end
      SCAN_NUMBER: begin
        if (is_digit(b)) begin
          // magnitude may reach 2^63 only for a negative value
          lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          if (mag > (lim - d) / 64'd10) begin
            owe(ST_ABSENT, 8'h00, '0, 1'b1);
          end else begin
            mag        = mag * 64'd10 + d;
            have_digit = 1'b1;
            if (last) owe(ST_INT, 8'h00, signed_value(), 1'b1);
          end
        end else if (have_digit) begin
          owe(ST_INT, 8'h00, signed_value(), 1'b1);
        end else begin
          owe(ST_ABSENT, 8'h00, '0, 1'b1);
        end
      end
      default: ;  // value already given, wait for the end of body
    endcase
    if (last) clear_body();
    else if (body_closed) scan = SCAN_DONE;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest one owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (extract_results.size() == 0) begin
        $error("result with none owed: status %0d char %0h number %0d last %0b",
               out_item.status, out_item.char_out, out_item.number,
               out_item.run_last);
        errors++;
      end else begin
        want = extract_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          errors++;
        end
        if (out_item.char_out !== want.char_out) begin
          $error("char_out: expected %0h, got %0h", want.char_out, out_item.char_out);
          errors++;
        end
        if (out_item.number !== want.number) begin
          $error("number: expected %0d, got %0d", want.number, out_item.number);
          errors++;
        end
        if (out_item.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off when a test asks for one
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake means the block hung
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    // random sender gaps; valid stays high between back-to-back items
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_item.text_byte = b;
    in_item.body_end  = last;
    do @(posedge clk); while (in_stall);
    scan_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_queue();
    for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    body_q.delete();
    push_str(s);
    send_queue();
  endtask

  // sender stops until every owed result is in, then lets the block settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (extract_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_VALUE_MODE: cfg_mode    = data[0];
      REG_KEY_LENGTH: cfg_klen    = data[5:0];
      REG_KEY_W0:     key_word[0] = data;
      REG_KEY_W1:     key_word[1] = data;
      REG_KEY_W2:     key_word[2] = data;
      REG_KEY_W3:     key_word[3] = data;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] pack_key_word(int j);
    logic [63:0] w;
    for (int c = 0; c < 8; c++) w[8*c +: 8] = key_bytes[8*j + c];
    return w;
  endfunction

  // writes all six registers: mode and length from the arguments, key words from key_bytes
  task automatic load_key(input logic mode, input logic [5:0] klen);
    write_reg(REG_VALUE_MODE, {63'd0, mode});
    write_reg(REG_KEY_LENGTH, {58'd0, klen});
    write_reg(REG_KEY_W0, pack_key_word(0));
    write_reg(REG_KEY_W1, pack_key_word(1));
    write_reg(REG_KEY_W2, pack_key_word(2));
    write_reg(REG_KEY_W3, pack_key_word(3));
  endtask

  task automatic set_key_text(input string k, input logic mode, input logic [5:0] klen);
    for (int i = 0; i < 32; i++) key_bytes[i] = (i < k.len()) ? k[i] : 8'h00;
    load_key(mode, klen);
  endtask

  // --------------------------------------------------------------------------
  // Random body content
  // --------------------------------------------------------------------------
  function automatic logic [7:0] sep_byte();
    case ($urandom_range(2))
      0:       return CHAR_COLON;
      1:       return CHAR_SPACE;
      default: return CHAR_TAB;
    endcase
  endfunction

  function automatic logic [7:0] digit_byte();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  // biased toward bytes the scanner cares about, incl. partial key matches
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0:       return CHAR_QUOTE;
      1:       return sep_byte();
      2:       return digit_byte();
      3:       return key_bytes[$urandom_range(31)];
      4:       return CHAR_MINUS;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_string();
    logic [7:0] c;
    body_q.push_back(CHAR_QUOTE);
    repeat ($urandom_range(0, 10)) begin
      do c = 8'($urandom_range(255)); while (c == CHAR_QUOTE);
      body_q.push_back(c);
    end
    if ($urandom_range(4) != 0) body_q.push_back(CHAR_QUOTE);  // else left open
  endtask

  task automatic add_number();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      if ($urandom_range(1)) body_q.push_back(CHAR_MINUS);
      repeat ($urandom_range(1, 6)) body_q.push_back(digit_byte());
    end else if (r < 70) begin
      // long runs, many of them overflow
      if ($urandom_range(1)) body_q.push_back(CHAR_MINUS);
      repeat ($urandom_range(15, 21)) body_q.push_back(digit_byte());
    end else if (r < 92) begin
      case ($urandom_range(6))
        0: push_str("9223372036854775807");    // largest positive
        1: push_str("-9223372036854775808");   // most negative
        2: push_str("9223372036854775808");    // one past positive range
        3: push_str("-9223372036854775809");   // one past negative range
        4: push_str("-0");
        5: push_str("00000000000000000000000042");
        default: push_str("18446744073709551615");
      endcase
    end else if (r < 96) begin
      body_q.push_back(CHAR_MINUS);            // sign with no digits
    end
    case ($urandom_range(3))
      0: ;                                     // body may end on a digit
      1: push_str(",");
      2: push_str("}");
      default: body_q.push_back(CHAR_SPACE);
    endcase
  endtask

  // mostly well-formed bodies with random content; some noise, some cut short
  task automatic make_body();
    int kind;
    int n;
    int klen;
    body_q.delete();
    klen = (cfg_klen > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(cfg_klen);
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 5)) body_q.push_back(noise_byte());
      body_q.push_back(CHAR_QUOTE);
      for (int i = 0; i < klen; i++) body_q.push_back(key_bytes[i]);
      body_q.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 3)) body_q.push_back(sep_byte());
      if ($urandom_range(9) == 0) body_q.push_back(noise_byte());  // likely a bad lead
      else if (cfg_mode == MODE_STRING) add_string();
      else add_number();
      repeat ($urandom_range(0, 4)) body_q.push_back(noise_byte());
      if (kind < 27) begin
        n = $urandom_range(1, body_q.size());
        while (body_q.size() > n) void'(body_q.pop_back());
      end
    end
  endtask

  task automatic random_config();
    int r;
    int style;
    logic [5:0] klen;
    r = $urandom_range(99);
    if (r < 45) klen = 6'($urandom_range(1, 6));
    else if (r < 55) klen = 6'd0;
    else if (r < 75) klen = 6'($urandom_range(7, 31));
    else if (r < 88) klen = 6'd32;
    else klen = 6'($urandom_range(33, 63));         // clipped to the longest key
    style = $urandom_range(19);
    for (int i = 0; i < 32; i++) begin
      case (style)
        0:       key_bytes[i] = 8'h00;
        1:       key_bytes[i] = 8'hFF;
        2, 3:    key_bytes[i] = 8'($urandom_range(255));
        default: key_bytes[i] = "a" + 8'($urandom_range(25));
      endcase
    end
    load_key(1'($urandom_range(1)), klen);
  endtask

  task automatic random_phase();
    wait_idle();
    random_config();
    repeat ($urandom_range(4, 10)) begin
      make_body();
      send_queue();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty key, so the pattern is just two quotes
  task automatic test_string_value();
    wait_idle();
    set_key_text("", MODE_STRING, 6'd0);
    send_text("\"\":\"z\"");           // plain value
    send_text("\"\"\"\"");             // empty string
    send_text("x");                    // key never seen
    send_text("\"\"");                 // ends on the key's closing quote
    send_text("\"\" \t");              // ends among separators
    send_text("\"\"x\"\"");            // bad lead, tail ignored
    send_text("\"\"\"ab");             // value never closed
    send_text("\"\"\"");               // opening quote is the last byte
    send_text("q\"\"\"k\"\"\"\"m\"");  // later occurrence not searched
  endtask

  task automatic test_integer_value();
    wait_idle();
    set_key_text("id", MODE_INT, 6'd2);
    send_text("\"id\": 42,");
    send_text("\"id\"\t-7");           // digit on the final byte counts
    send_text("\"id\":-");             // sign on the final byte
    send_text("\"id\":-x");            // sign without digits
    send_text("\"id\":x1");            // bad lead
    send_text("\"id\":5");             // lone lead digit ends the body
    send_text("\"id\":1 \"id\":2");
    send_text("{\"i\":3}");
    send_text("\"id\":0");
  endtask

  // length register at its maximum, clipped to the longest key
  task automatic test_long_key();
    wait_idle();
    set_key_text("abcdefghijklmnopqrstuvwxyz012345", MODE_INT, 6'd63);
    send_text("\"abcdefghijklmnopqrstuvwxyz012345\":-9}");
  endtask

  // receiver holds off while the sender keeps offering: the block fills and
  // must stall its input without losing or repeating anything
  task automatic test_output_backpressure();
    wait_idle();
    set_key_text("s", MODE_STRING, 6'd1);
    hold_left = 150;
    repeat (2) begin
      body_q.delete();
      push_str("\"s\":\"");
      repeat (40) body_q.push_back("a" + 8'($urandom_range(25)));
      body_q.push_back(CHAR_QUOTE);
      send_queue();
    end
  endtask

  // back-to-back items and no stalls
  task automatic test_steady_stream();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (3) random_phase();
    wait_idle();
    idle_pct  = 31;
    stall_pct = 31;
  endtask

  // tops the run up to at least 1000 items in total
  task automatic test_random_bodies();
    while (bytes_sent < 1000) random_phase();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cfg_mode  = MODE_STRING;
    cfg_klen  = '0;
    for (int j = 0; j < 4; j++) key_word[j] = '0;
    clear_body();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_string_value();
    test_integer_value();
    test_long_key();
    test_output_backpressure();
    test_steady_stream();
    test_random_bodies();

    wait_idle();
    repeat (8) @(posedge clk);  // any late extra result shows up here
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
